FILE: hdl/sgcq_pkg.sv
// Package for the stereo gain, clip and quantizer block.
// Holds the sequencer state type, fixed-point constants and register indexes.
// Has no dependencies of its own.
package sgcq_pkg;

   // Sequencer states; each arithmetic state drives the shared multiplier once.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_EVAL,
      ST_DIV3,
      ST_SQUARE,
      ST_POLY,
      ST_DIV5,
      ST_SCALE,
      ST_QUANT,
      ST_DONE
   } state_type;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 23;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Q20 constants.
   localparam logic [20:0] ONE_Q20        = 21'd1048576;
   localparam logic [20:0] THRESH_Q20     = 21'd838861;
   localparam logic [20:0] THREE_HALF_Q20 = 21'd1572864;

   // Excess over the threshold from which the cubic term saturates at one.
   localparam logic [24:0] KNEE_SAT_LIMIT = 25'd314573;

   // Reciprocals: floor(x/3) = (x * RECIP3) >> 24 for x < 2^22,
   // floor(x/5) = (x * RECIP5) >> 24 for x < 2^21.
   localparam logic [22:0] RECIP3 = 23'd5592406;
   localparam logic [21:0] RECIP5 = 22'd3355444;

   // Output scaling and peak limits.
   localparam logic [14:0] PCM_FULL = 15'd32767;
   localparam logic [24:0] PRE_MAX  = 25'h1FF_FFFF;
   localparam logic [14:0] POST_MAX = 15'h7FFF;

   // Configuration register indexes and reset values.
   localparam logic [0:0]  REG_GAIN        = 1'b0;
   localparam logic [0:0]  REG_CLIP_MODE   = 1'b1;
   localparam logic [15:0] GAIN_RESET      = 16'd16384;
   localparam logic        CLIP_MODE_RESET = 1'b0;

endpackage

FILE: hdl/stereo_gain_clip_quantizer_top.sv
// Stereo gain, soft or hard clip and 16-bit quantizer with peak tracking.
// Depends on sgcq_pkg for the state type and fixed-point constants.
//
// Usage: a stereo pair in signed Q4.20 enters on the req_ channel (valid and
// ready) and one transaction leaves on the rsp_ channel with both 16-bit PCM
// samples and the four running peak values after this pair. Setting
// req_clear_peaks zeroes all peak trackers before the pair is processed.
// The gain (index 0, Q2.14) and the clip mode (index 1) are written through
// the csr_ port; the user must write them only while the block is idle, as
// the block itself does not enforce this.
// One shared 24x23 multiplier is sequenced through each channel in turn. A
// channel runs GAIN, EVAL, SCALE and QUANT in hard mode or below the
// soft-clip knee, adds DIV5 when the cubic term saturates and adds DIV3,
// SQUARE, POLY and DIV5 on the cubic path. The block accepts one pair at a
// time; req_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new pair is accepted while an
// earlier result waits; if the receiver is still stalling when the next
// result is finished, the sequencer holds it until the register frees.
// Reset (synchronous, active high) restores unity gain, soft mode, clears
// all peak trackers and drops rsp_valid.
module stereo_gain_clip_quantizer_top (
   input  logic               clock,
   input  logic               reset,
   // Input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_left_in,
   input  logic signed [23:0] req_right_in,
   input  logic               req_clear_peaks,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   output logic        [24:0] rsp_peak_pre_left,
   output logic        [24:0] rsp_peak_pre_right,
   output logic        [14:0] rsp_peak_post_left,
   output logic        [14:0] rsp_peak_post_right,
   // Configuration port
   input  logic               csr_wr_en,
   input  logic        [0:0]  csr_index,
   input  logic        [15:0] csr_wdata
);

   sgcq_pkg::state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] gain_ff;
   logic        clip_mode_ff;

   // Peak trackers.
   logic [24:0] peak_pre_l_ff, peak_pre_l_in;
   logic [24:0] peak_pre_r_ff, peak_pre_r_in;
   logic [14:0] peak_post_l_ff, peak_post_l_in;
   logic [14:0] peak_post_r_ff, peak_post_r_in;

   // Working registers of the sequencer.
   logic                          ch_ff, ch_in;
   logic [23:0]                   mag_l_ff, mag_l_in;
   logic [23:0]                   mag_r_ff, mag_r_in;
   logic                          neg_l_ff, neg_l_in;
   logic                          neg_r_ff, neg_r_in;
   logic [sgcq_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [21:0]                   x_ff, x_in;
   logic [19:0]                   u_ff, u_in;
   logic [20:0]                   y_ff, y_in;
   logic                          soft_ff, soft_in;
   logic                          sat_ff, sat_in;
   logic [15:0]                   pcm_l_ff, pcm_l_in;
   logic [15:0]                   pcm_r_ff, pcm_r_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] out_left_ff, out_right_ff;
   logic [24:0] out_pre_l_ff, out_pre_r_ff;
   logic [14:0] out_post_l_ff, out_post_r_ff;

   // Shared multiplier.
   logic [sgcq_pkg::MUL_A_W-1:0] mul_a;
   logic [sgcq_pkg::MUL_B_W-1:0] mul_b;

   // Intermediate values.
   logic        accept;
   logic        out_free;
   logic        load_out;
   logic [23:0] req_mag_l, req_mag_r;
   logic [25:0] m_wide;
   logic [24:0] m_sat;
   logic [24:0] excess;
   logic [24:0] peak_pre_cur;
   logic [14:0] peak_post_cur;
   logic [19:0] u_cur;
   logic [19:0] u_sq;
   logic [20:0] poly_f;
   logic [20:0] s_cur;
   logic [20:0] y_knee;
   logic [20:0] y_cur;
   logic [15:0] q_wide;
   logic [14:0] q_mag;
   logic [15:0] pcm_cur;

   // Handshake terms.
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (state_ff == sgcq_pkg::ST_DONE) && out_free;

   // Magnitudes of the incoming samples; the most negative code maps to 2^23.
   assign req_mag_l = req_left_in[23]  ? (24'd0 - $unsigned(req_left_in))
                                       : $unsigned(req_left_in);
   assign req_mag_r = req_right_in[23] ? (24'd0 - $unsigned(req_right_in))
                                       : $unsigned(req_right_in);

   // Gained magnitude in Q5.20 and its excess over the soft-clip knee.
   assign m_wide = prod_ff[39:14];
   assign m_sat  = m_wide[25] ? sgcq_pkg::PRE_MAX : m_wide[24:0];
   assign excess = m_sat - {4'd0, sgcq_pkg::THRESH_Q20};

   assign peak_pre_cur  = ch_ff ? peak_pre_r_ff  : peak_pre_l_ff;
   assign peak_post_cur = ch_ff ? peak_post_r_ff : peak_post_l_ff;

   // Cubic terms taken from the previous multiplier pass.
   assign u_cur  = prod_ff[43:24];
   assign u_sq   = prod_ff[39:20];
   assign poly_f = sgcq_pkg::THREE_HALF_Q20 - {2'd0, u_sq[19:1]};
   assign s_cur  = sat_ff ? sgcq_pkg::ONE_Q20 : prod_ff[40:20];

   // Knee plus a fifth of the cubic term, limited to one.
   always_comb begin
      y_knee = sgcq_pkg::THRESH_Q20 + {2'd0, prod_ff[42:24]};
      if (y_knee > sgcq_pkg::ONE_Q20) begin
         y_knee = sgcq_pkg::ONE_Q20;
      end
   end

   assign y_cur = soft_ff ? y_knee : y_ff;

   // Quantized magnitude and signed PCM value of the current channel.
   assign q_wide  = prod_ff[35:20];
   assign q_mag   = (q_wide > {1'b0, sgcq_pkg::POST_MAX}) ? sgcq_pkg::POST_MAX
                                                          : q_wide[14:0];
   assign pcm_cur = (ch_ff ? neg_r_ff : neg_l_ff) ? (16'd0 - {1'b0, q_mag})
                                                  : {1'b0, q_mag};

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         sgcq_pkg::ST_GAIN: begin
            mul_a = ch_ff ? mag_r_ff : mag_l_ff;
            mul_b = {7'd0, gain_ff};
         end
         sgcq_pkg::ST_DIV3: begin
            mul_a = {2'd0, x_ff};
            mul_b = sgcq_pkg::RECIP3;
         end
         sgcq_pkg::ST_SQUARE: begin
            mul_a = {4'd0, u_cur};
            mul_b = {3'd0, u_cur};
         end
         sgcq_pkg::ST_POLY: begin
            mul_a = {4'd0, u_ff};
            mul_b = {2'd0, poly_f};
         end
         sgcq_pkg::ST_DIV5: begin
            mul_a = {3'd0, s_cur};
            mul_b = {1'b0, sgcq_pkg::RECIP5};
         end
         sgcq_pkg::ST_SCALE: begin
            mul_a = {3'd0, y_cur};
            mul_b = {8'd0, sgcq_pkg::PCM_FULL};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = sgcq_pkg::PROD_W'(mul_a) * sgcq_pkg::PROD_W'(mul_b);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgcq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sgcq_pkg::ST_GAIN;
            end
         end
         sgcq_pkg::ST_GAIN: begin
            state_in = sgcq_pkg::ST_EVAL;
         end
         sgcq_pkg::ST_EVAL: begin
            if (!clip_mode_ff && (m_sat >= {4'd0, sgcq_pkg::THRESH_Q20})) begin
               state_in = (excess >= sgcq_pkg::KNEE_SAT_LIMIT) ? sgcq_pkg::ST_DIV5
                                                               : sgcq_pkg::ST_DIV3;
            end else begin
               state_in = sgcq_pkg::ST_SCALE;
            end
         end
         sgcq_pkg::ST_DIV3: begin
            state_in = sgcq_pkg::ST_SQUARE;
         end
         sgcq_pkg::ST_SQUARE: begin
            state_in = sgcq_pkg::ST_POLY;
         end
         sgcq_pkg::ST_POLY: begin
            state_in = sgcq_pkg::ST_DIV5;
         end
         sgcq_pkg::ST_DIV5: begin
            state_in = sgcq_pkg::ST_SCALE;
         end
         sgcq_pkg::ST_SCALE: begin
            state_in = sgcq_pkg::ST_QUANT;
         end
         sgcq_pkg::ST_QUANT: begin
            state_in = ch_ff ? sgcq_pkg::ST_DONE : sgcq_pkg::ST_GAIN;
         end
         sgcq_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = sgcq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgcq_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ready = (state_ff == sgcq_pkg::ST_IDLE);
      rsp_valid = rsp_valid_ff;
   end

   // Working values and peak trackers for the next cycle.
   always_comb begin
      ch_in          = ch_ff;
      mag_l_in       = mag_l_ff;
      mag_r_in       = mag_r_ff;
      neg_l_in       = neg_l_ff;
      neg_r_in       = neg_r_ff;
      x_in           = x_ff;
      u_in           = u_ff;
      y_in           = y_ff;
      soft_in        = soft_ff;
      sat_in         = sat_ff;
      pcm_l_in       = pcm_l_ff;
      pcm_r_in       = pcm_r_ff;
      peak_pre_l_in  = peak_pre_l_ff;
      peak_pre_r_in  = peak_pre_r_ff;
      peak_post_l_in = peak_post_l_ff;
      peak_post_r_in = peak_post_r_ff;

      // Capture the pair and clear the trackers when asked to.
      if (accept) begin
         ch_in    = 1'b0;
         mag_l_in = req_mag_l;
         mag_r_in = req_mag_r;
         neg_l_in = req_left_in[23];
         neg_r_in = req_right_in[23];
         if (req_clear_peaks) begin
            peak_pre_l_in  = '0;
            peak_pre_r_in  = '0;
            peak_post_l_in = '0;
            peak_post_r_in = '0;
         end
      end

      // Gained magnitude: update the pre-clip peak and choose the clip path.
      if (state_ff == sgcq_pkg::ST_EVAL) begin
         if (m_sat > peak_pre_cur) begin
            if (ch_ff) begin
               peak_pre_r_in = m_sat;
            end else begin
               peak_pre_l_in = m_sat;
            end
         end
         soft_in = !clip_mode_ff && (m_sat >= {4'd0, sgcq_pkg::THRESH_Q20});
         sat_in  = excess >= sgcq_pkg::KNEE_SAT_LIMIT;
         x_in    = (22'(excess[18:0]) << 3) + (22'(excess[18:0]) << 1);
         if (clip_mode_ff && (m_sat >= {4'd0, sgcq_pkg::ONE_Q20})) begin
            y_in = sgcq_pkg::ONE_Q20;
         end else begin
            y_in = m_sat[20:0];
         end
      end

      // Keep u for the polynomial pass.
      if (state_ff == sgcq_pkg::ST_SQUARE) begin
         u_in = u_cur;
      end

      // Quantized sample: update the post-clip peak and store the PCM value.
      if (state_ff == sgcq_pkg::ST_QUANT) begin
         ch_in = !ch_ff;
         if (ch_ff) begin
            pcm_r_in = pcm_cur;
            if (q_mag > peak_post_cur) begin
               peak_post_r_in = q_mag;
            end
         end else begin
            pcm_l_in = pcm_cur;
            if (q_mag > peak_post_cur) begin
               peak_post_l_in = q_mag;
            end
         end
      end
   end

   // Result register valid flag.
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   // Control state, configuration and peak trackers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sgcq_pkg::ST_IDLE;
         ch_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         gain_ff        <= sgcq_pkg::GAIN_RESET;
         clip_mode_ff   <= sgcq_pkg::CLIP_MODE_RESET;
         peak_pre_l_ff  <= '0;
         peak_pre_r_ff  <= '0;
         peak_post_l_ff <= '0;
         peak_post_r_ff <= '0;
      end else begin
         state_ff       <= state_in;
         ch_ff          <= ch_in;
         rsp_valid_ff   <= rsp_valid_in;
         peak_pre_l_ff  <= peak_pre_l_in;
         peak_pre_r_ff  <= peak_pre_r_in;
         peak_post_l_ff <= peak_post_l_in;
         peak_post_r_ff <= peak_post_r_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               sgcq_pkg::REG_GAIN:      gain_ff      <= csr_wdata;
               sgcq_pkg::REG_CLIP_MODE: clip_mode_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mag_l_ff <= mag_l_in;
      mag_r_ff <= mag_r_in;
      neg_l_ff <= neg_l_in;
      neg_r_ff <= neg_r_in;
      x_ff     <= x_in;
      u_ff     <= u_in;
      y_ff     <= y_in;
      soft_ff  <= soft_in;
      sat_ff   <= sat_in;
      pcm_l_ff <= pcm_l_in;
      pcm_r_ff <= pcm_r_in;
      if (load_out) begin
         out_left_ff   <= pcm_l_ff;
         out_right_ff  <= pcm_r_ff;
         out_pre_l_ff  <= peak_pre_l_ff;
         out_pre_r_ff  <= peak_pre_r_ff;
         out_post_l_ff <= peak_post_l_ff;
         out_post_r_ff <= peak_post_r_ff;
      end
   end

   // Result payload.
   assign rsp_left_out        = $signed(out_left_ff);
   assign rsp_right_out       = $signed(out_right_ff);
   assign rsp_peak_pre_left   = out_pre_l_ff;
   assign rsp_peak_pre_right  = out_pre_r_ff;
   assign rsp_peak_post_left  = out_post_l_ff;
   assign rsp_peak_post_right = out_post_r_ff;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the stereo gain, clip and quantizer block.
// Depends on sgcq_pkg for the register indexes and on the top-level RTL.
// A local predictor computes each expected result frame from the accepted stereo pair.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed-point constants of the predictor, in Q20 unless stated.
   localparam bit [63:0] UNIT_Q20   = 64'd1048576;
   localparam bit [63:0] KNEE_Q20   = 64'd838861;
   localparam bit [63:0] SLOPE_Q20  = 64'd1572864;
   localparam bit [63:0] PCM_SCALE  = 64'd32767;
   localparam bit [63:0] PRE_LIMIT  = 64'd33554431;
   localparam bit [63:0] POST_LIMIT = 64'd32767;

   // Run control.
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 400;

   // One result frame, laid out as the rsp_ channel carries it.
   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic [24:0] pre_l;
      logic [24:0] pre_r;
      logic [14:0] post_l;
      logic [14:0] post_r;
   } frame_type;

   // Block ports; every input starts at a known value.
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [23:0] req_left_in     = '0;
   logic [23:0] req_right_in    = '0;
   logic        req_clear_peaks = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [15:0] rsp_left_out;
   logic [15:0] rsp_right_out;
   logic [24:0] rsp_peak_pre_left;
   logic [24:0] rsp_peak_pre_right;
   logic [14:0] rsp_peak_post_left;
   logic [14:0] rsp_peak_post_right;
   logic        csr_wr_en       = 1'b0;
   logic [0:0]  csr_index       = '0;
   logic [15:0] csr_wdata       = '0;

   // Predictor copy of the configuration and the peak trackers.
   logic [15:0] cfg_gain  = 16'd16384;
   logic        cfg_hard  = 1'b0;
   logic [24:0] pk_pre_l  = '0;
   logic [24:0] pk_pre_r  = '0;
   logic [14:0] pk_post_l = '0;
   logic [14:0] pk_post_r = '0;

   // Expected result frames, oldest first, and run bookkeeping.
   frame_type expected_frames[$];
   int     mismatches     = 0;
   int     pairs_sent     = 0;
   int     frames_checked = 0;
   int     cycle_count    = 0;
   int     send_idle_pct  = 0;
   int     recv_idle_pct  = 0;
   int     hold_left      = 0;

   stereo_gain_clip_quantizer_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_left_in         (req_left_in),
      .req_right_in        (req_right_in),
      .req_clear_peaks     (req_clear_peaks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_out        (rsp_left_out),
      .rsp_right_out       (rsp_right_out),
      .rsp_peak_pre_left   (rsp_peak_pre_left),
      .rsp_peak_pre_right  (rsp_peak_pre_right),
      .rsp_peak_post_left  (rsp_peak_post_left),
      .rsp_peak_post_right (rsp_peak_post_right),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Free-running clock, 10 ns period.
   always #5 clock = ~clock;

   // Clip one gained magnitude with the current mode.
   function automatic bit [63:0] clip_magnitude(input bit [63:0] mag);
      bit [63:0] excess;
      bit [63:0] sq;
      bit [63:0] shaped;
      bit [63:0] y;
      if (cfg_hard) begin
         y = (mag < UNIT_Q20) ? mag : UNIT_Q20;
      end else if (mag < KNEE_Q20) begin
         y = mag;
      end else begin
         // Above the knee the excess is rescaled so that 0.3 maps to one.
         excess = ((mag - KNEE_Q20) * 10) / 3;
         if (excess >= UNIT_Q20) begin
            shaped = UNIT_Q20;
         end else begin
            sq     = (excess * excess) >> 20;
            shaped = (excess * (SLOPE_Q20 - (sq >> 1))) >> 20;
         end
         y = KNEE_Q20 + shaped / 5;
         if (y > UNIT_Q20) y = UNIT_Q20;
      end
      return y;
   endfunction

   // Gain, clip and quantise one channel, updating its peak trackers.
   function automatic void shape_channel(input logic [23:0] raw, output logic [15:0] pcm,
                                         inout logic [24:0] pre, inout logic [14:0] post);
      bit        neg;
      bit [63:0] mag;
      bit [63:0] gained;
      bit [63:0] q;
      neg    = raw[23];
      mag    = neg ? (64'h100_0000 - {40'd0, raw}) : {40'd0, raw};
      gained = (mag * {48'd0, cfg_gain}) >> 14;
      if (gained > PRE_LIMIT) gained = PRE_LIMIT;
      if (gained > {39'd0, pre}) pre = gained[24:0];
      q = (clip_magnitude(gained) * PCM_SCALE) >> 20;
      if (q > POST_LIMIT) q = POST_LIMIT;
      if (q > {49'd0, post}) post = q[14:0];
      // The sign is restored last, so a zero magnitude gives zero either way.
      pcm = neg ? (16'h0000 - q[15:0]) : q[15:0];
   endfunction

   // Expected frame for one accepted stereo pair.
   function automatic frame_type predict_frame(input logic [23:0] left,
                                               input logic [23:0] right,
                                               input logic clr);
      frame_type f;
      if (clr) begin
         pk_pre_l  = '0;
         pk_pre_r  = '0;
         pk_post_l = '0;
         pk_post_r = '0;
      end
      shape_channel(left, f.left, pk_pre_l, pk_post_l);
      shape_channel(right, f.right, pk_pre_r, pk_post_r);
      f.pre_l  = pk_pre_l;
      f.pre_r  = pk_pre_r;
      f.post_l = pk_post_l;
      f.post_r = pk_post_r;
      return f;
   endfunction

   // Random sample: full range, around the knee, tiny, or near full scale.
   function automatic logic [23:0] pick_sample();
      logic [23:0] v;
      case ($urandom_range(3))
         0:       v = 24'($urandom);
         1:       v = 24'($urandom_range(1400000, 700000));
         2:       v = 24'($urandom_range(4095));
         default: v = 24'($urandom_range(8388607, 6000000));
      endcase
      if ($urandom_range(1)) v = -v;
      return v;
   endfunction

   // Random gain with its extremes and unity weighted in.
   function automatic logic [15:0] pick_gain();
      case ($urandom_range(4))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'd16384;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(30000, 12000));
      endcase
   endfunction

   // Print one failure line and count it.
   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [24:0] got,
                              input logic [24:0] want);
      if (got !== want)
         report_mismatch($sformatf("frame %0d %s: got 0x%0h, expected 0x%0h",
                                   frames_checked, name, got, want));
   endtask

   // Offer one stereo pair after a random gap and record its expected frame on acceptance.
   task automatic send_pair(input logic [23:0] left, input logic [23:0] right,
                            input logic clr);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_left_in     <= left;
      req_right_in    <= right;
      req_clear_peaks <= clr;
      do @(posedge clock); while (!req_ready);
      expected_frames.push_back(predict_frame(left, right, clr));
      pairs_sent++;
   endtask

   // Stop offering and wait until every expected frame has arrived, then let the block settle.
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_frames.size() != 0) begin
         report_mismatch($sformatf("%0d expected frames never arrived",
                                   expected_frames.size()));
         expected_frames.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the predictor follows the kept bits.
   task automatic write_csr(input logic [0:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == sgcq_pkg::REG_GAIN) cfg_gain = data;
      else                           cfg_hard = data[0];
   endtask

   // Clip mode write with the unused upper bits randomised.
   task automatic write_mode(input logic hard);
      logic [15:0] data;
      data    = 16'($urandom);
      data[0] = hard;
      write_csr(sgcq_pkg::REG_CLIP_MODE, data);
   endtask

   // Reset values: unity gain, soft clip, across the knee and both full scales.
   task automatic test_unity_soft();
      send_pair(24'd0, 24'd0, 1'b0);
      send_pair(24'd838860, -24'sd838861, 1'b0);
      send_pair(24'd943718, -24'sd943718, 1'b0);
      send_pair(24'd1258291, -24'sd1048576, 1'b0);
      send_pair(24'h7F_FFFF, 24'h80_0000, 1'b0);
      send_pair(-24'sd1, 24'd1, 1'b1);
      send_pair(24'd1048576, 24'd1000000, 1'b0);
   endtask

   // Zero gain gives signed zeros; full gain drives everything into the clipper.
   task automatic test_gain_extremes();
      drain_results();
      write_csr(sgcq_pkg::REG_GAIN, 16'd0);
      write_csr(sgcq_pkg::REG_CLIP_MODE, 16'hFFFE);
      send_pair(24'h7F_FFFF, 24'h80_0000, 1'b0);
      send_pair(-24'sd5, 24'd123456, 1'b1);
      drain_results();
      write_csr(sgcq_pkg::REG_GAIN, 16'hFFFF);
      send_pair(24'h7F_FFFF, 24'h80_0000, 1'b0);
      send_pair(24'd300000, -24'sd262144, 1'b0);
   endtask

   // Hard clamp at one, just either side of full scale.
   task automatic test_hard_clamp();
      drain_results();
      write_mode(1'b1);
      write_csr(sgcq_pkg::REG_GAIN, 16'd16384);
      send_pair(24'd1048575, -24'sd1048575, 1'b1);
      send_pair(24'd1048576, -24'sd1048577, 1'b0);
      send_pair(24'd800000, 24'h80_0000, 1'b0);
      send_pair(24'h7F_FFFF, 24'd0, 1'b0);
      drain_results();
      write_csr(sgcq_pkg::REG_GAIN, 16'hFFFF);
      send_pair(24'h40_0000, -24'sd256, 1'b1);
   endtask

   // Random pairs in three configuration chunks with the given idle rates.
   task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int chunk = 0; chunk < 3; chunk++) begin
         drain_results();
         write_csr(sgcq_pkg::REG_GAIN, pick_gain());
         write_mode(1'($urandom_range(1)));
         for (int i = 0; i < n_items / 3; i++)
            send_pair(pick_sample(), pick_sample(), ($urandom_range(19) == 0));
      end
   endtask

   // Long output stall while pairs keep coming, a pause until everything drains, then eight more pairs.
   task automatic test_backpressure();
      drain_results();
      write_csr(sgcq_pkg::REG_GAIN, 16'd16384);
      write_mode(1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 20;
      hold_left     = HOLD_CYCLES;
      for (int i = 0; i < 16; i++)
         send_pair(pick_sample(), pick_sample(), (i == 0));
      drain_results();
      for (int i = 0; i < 8; i++)
         send_pair(pick_sample(), pick_sample(), 1'b0);
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted result transaction with the oldest expected frame.
   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("result transaction with no expected frame waiting");
         end else begin
            want = expected_frames.pop_front();
            check_field("left_out", {9'd0, rsp_left_out}, {9'd0, want.left});
            check_field("right_out", {9'd0, rsp_right_out}, {9'd0, want.right});
            check_field("peak_pre_left", rsp_peak_pre_left, want.pre_l);
            check_field("peak_pre_right", rsp_peak_pre_right, want.pre_r);
            check_field("peak_post_left", {10'd0, rsp_peak_post_left},
                        {10'd0, want.post_l});
            check_field("peak_post_right", {10'd0, rsp_peak_post_right},
                        {10'd0, want.post_r});
         end
         frames_checked++;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d frames outstanding",
                  cycle_count, expected_frames.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_unity_soft();
      test_gain_extremes();
      test_hard_clamp();
      test_random_traffic(36, 63, 180);
      test_random_traffic(63, 36, 180);
      test_random_traffic(0, 0, 180);
      test_backpressure();
      drain_results();
      $display("Summary: %0d stereo pairs sent and %0d result frames checked in soft and hard",
               pairs_sent, frames_checked);
      $display("modes, with gain extremes, peak clears and a %0d-cycle output stall.",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/sgcq_pkg.sv
hdl/stereo_gain_clip_quantizer_top.sv
tb/tb.sv
